@@ design/kcht_pkg.sv @@
// Package for the keyed counter hash table: operation and status codes,
// FNV-1a constants, default sizes and the back-end state type. No dependencies.
package kcht_pkg;

  localparam int unsigned CHANNELS_DEF    = 4;
  localparam int unsigned BUCKETS_DEF     = 8;
  localparam int unsigned MAX_ENTRIES_DEF = 256;
  localparam int unsigned LABEL_BYTES_DEF = 16;
  localparam int unsigned SLOTS_DEF       = 512;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_RSVD  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_REJECTED = 3'd2,
    ST_ANSWERED = 3'd3,
    ST_CLEARED  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_MOD,
    BK_SLOT_RD,
    BK_SLOT_CHK,
    BK_ENT_CHK
  } bk_state_t;

endpackage

@@ design/kcht_front.sv @@
// Front end: takes label bytes, folds the FNV-1a hash, buffers the label and
// classifies the command on the last byte. Depends on kcht_pkg.
module kcht_front import kcht_pkg::*; #(
  parameter int unsigned CHANNELS    = CHANNELS_DEF,
  parameter int unsigned BUCKETS     = BUCKETS_DEF,
  parameter int unsigned LABEL_BYTES = LABEL_BYTES_DEF,
  localparam int unsigned TABLES = CHANNELS * BUCKETS,
  localparam int unsigned TBL_W  = (TABLES > 1) ? $clog2(TABLES) : 1,
  localparam int unsigned LBL_W  = LABEL_BYTES * 8,
  localparam int unsigned CMD_W  = 4 + TBL_W + 32 + LBL_W + 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [1:0]       in_op,
  input  logic [1:0]       in_channel,
  input  logic [2:0]       in_bucket,
  input  logic [7:0]       in_key_char,
  input  logic             in_char_present,
  input  logic             in_key_last,
  input  logic [31:0]      in_start_value,
  input  logic [31:0]      in_delta,
  output logic             cmd_push,
  output logic [CMD_W-1:0] cmd_data
);

  localparam int unsigned LEN_W = $clog2(LABEL_BYTES + 1);
  localparam int unsigned IDX_W = $clog2(LABEL_BYTES);

  logic [31:0]      hash_r, hash_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LBL_W-1:0] buf_r, buf_nxt;

  logic             take;
  logic [31:0]      mixed, prod;
  logic [31:0]      lab_hash;
  logic [LEN_W-1:0] lab_len;
  logic [LBL_W-1:0] lab_buf;
  logic             fits, tvalid;
  logic [TBL_W-1:0] tbl;

  always_comb begin
    take     = in_char_present && (in_key_char != 8'd0);
    mixed    = hash_r ^ {24'd0, in_key_char};
    prod     = mixed * FNV_PRIME;
    lab_hash = take ? prod : hash_r;
    lab_len  = len_r;
    lab_buf  = buf_r;
    if (take && (len_r < LEN_W'(LABEL_BYTES))) begin
      lab_len = len_r + 1'b1;
      lab_buf[len_r[IDX_W-1:0]*8 +: 8] = in_key_char;
    end
    fits   = lab_len < LEN_W'(LABEL_BYTES);
    tvalid = (32'(in_channel) < CHANNELS) && (32'(in_bucket) < BUCKETS);
    tbl    = tvalid ? TBL_W'(32'(in_channel) * BUCKETS + 32'(in_bucket)) : '0;

    hash_nxt = hash_r;
    len_nxt  = len_r;
    buf_nxt  = buf_r;
    if (accept) begin
      if (in_key_last) begin
        hash_nxt = FNV_BASIS;
        len_nxt  = '0;
        buf_nxt  = '0;
      end else begin
        hash_nxt = lab_hash;
        len_nxt  = lab_len;
        buf_nxt  = lab_buf;
      end
    end
    cmd_push = accept && in_key_last;
    cmd_data = {in_op, tvalid, fits, tbl, lab_hash, lab_buf, in_start_value, in_delta};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= FNV_BASIS;
      len_r  <= '0;
      buf_r  <= '0;
    end else begin
      hash_r <= hash_nxt;
      len_r  <= len_nxt;
      buf_r  <= buf_nxt;
    end
  end

endmodule

@@ design/kcht_fifo.sv @@
// Two-entry command queue between front and back end.
// Depends on kcht_pkg only for the common import style.
module kcht_fifo import kcht_pkg::*; #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             avail,
  output logic             full,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  always_comb begin
    avail    = cnt_r != 2'd0;
    full     = cnt_r == 2'd2;
    pop_data = mem_r[rp_r];
    wp_nxt   = push ? ~wp_r : wp_r;
    rp_nxt   = pop ? ~rp_r : rp_r;
    cnt_nxt  = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ design/kcht_back.sv @@
// Back end: slot, label and count memories, linear probe sequencer, clear
// sweep and result register. Depends on kcht_pkg.
module kcht_back import kcht_pkg::*; #(
  parameter int unsigned CHANNELS    = CHANNELS_DEF,
  parameter int unsigned BUCKETS     = BUCKETS_DEF,
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int unsigned LABEL_BYTES = LABEL_BYTES_DEF,
  parameter int unsigned SLOTS       = SLOTS_DEF,
  localparam int unsigned TABLES = CHANNELS * BUCKETS,
  localparam int unsigned TBL_W  = (TABLES > 1) ? $clog2(TABLES) : 1,
  localparam int unsigned LBL_W  = LABEL_BYTES * 8,
  localparam int unsigned CMD_W  = 4 + TBL_W + 32 + LBL_W + 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_avail,
  input  logic [CMD_W-1:0] cmd_data,
  output logic             cmd_pop,
  output logic             init_busy,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       out_status,
  output logic [7:0]       out_entry_index,
  output logic [31:0]      out_count_value
);

  localparam int unsigned ENT_LIM  = (MAX_ENTRIES < SLOTS) ? MAX_ENTRIES : SLOTS;
  localparam int unsigned SV_W     = $clog2(ENT_LIM + 1);
  localparam int unsigned ENT_W    = $clog2(MAX_ENTRIES);
  localparam int unsigned SLOT_W   = $clog2(SLOTS);
  localparam int unsigned SA_DEPTH = TABLES * SLOTS;
  localparam int unsigned EA_DEPTH = TABLES * MAX_ENTRIES;
  localparam int unsigned SA_W     = $clog2(SA_DEPTH);
  localparam int unsigned EA_W     = $clog2(EA_DEPTH);
  localparam bit          POW2     = (SLOTS & (SLOTS - 1)) == 0;
  // hash / SLOTS = (hash * RCP) >> RCP_SH, exact for every 32-bit hash
  localparam int unsigned RCP_SH   = 32 + SLOT_W;
  localparam logic [32:0] RCP      =
    33'(((64'd1 << RCP_SH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));

  // memories
  logic [SV_W-1:0]  slot_mem  [SA_DEPTH];
  logic [LBL_W-1:0] label_mem [EA_DEPTH];
  logic [31:0]      count_mem [EA_DEPTH];
  logic [SV_W-1:0]  slot_q;
  logic [LBL_W-1:0] label_q;
  logic [31:0]      count_q;

  logic             slot_we, slot_re, ent_re, lbl_we, cnt_we;
  logic [SA_W-1:0]  slot_waddr, slot_raddr;
  logic [SV_W-1:0]  slot_wd;
  logic [EA_W-1:0]  ent_raddr, lbl_waddr, cnt_waddr;
  logic [31:0]      cnt_wd;

  // registers
  bk_state_t        state_r, state_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [TBL_W-1:0] tbl_r, tbl_nxt;
  logic [31:0]      hash_r, hash_nxt;
  logic [LBL_W-1:0] lbl_r, lbl_nxt;
  logic [31:0]      start_r, start_nxt, delta_r, delta_nxt;
  logic [SLOT_W-1:0] pos_r, pos_nxt, probes_r, probes_nxt;
  logic [64:0]      acc_r, acc_nxt;
  logic [1:0]       bit_r, bit_nxt;
  logic [ENT_W-1:0] e_r, e_nxt;
  logic [SA_W-1:0]  clr_r, clr_nxt;
  logic             report_r, report_nxt;
  logic [SV_W-1:0]  used_r [TABLES];
  logic [SV_W-1:0]  used_nxt [TABLES];
  logic             ov_r, ov_nxt;
  logic [2:0]       st_r, st_nxt;
  logic [7:0]       idx_r, idx_nxt;
  logic [31:0]      cv_r, cv_nxt;

  // decoded command
  logic [1:0]       c_op;
  logic             c_tv, c_fits;
  logic [TBL_W-1:0] c_tbl;
  logic [31:0]      c_hash, c_start, c_delta;
  logic [LBL_W-1:0] c_lbl;

  logic             go_absent, go_found;
  logic [31:0]      quot;
  logic [SV_W-1:0]  n_used;
  logic [32:0]      sum;
  logic [31:0]      sat;
  logic [SLOT_W-1:0] pos_inc;

  assign {c_op, c_tv, c_fits, c_tbl, c_hash, c_lbl, c_start, c_delta} = cmd_data;

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    tbl_nxt    = tbl_r;
    hash_nxt   = hash_r;
    lbl_nxt    = lbl_r;
    start_nxt  = start_r;
    delta_nxt  = delta_r;
    pos_nxt    = pos_r;
    acc_nxt    = acc_r;
    probes_nxt = probes_r;
    bit_nxt    = bit_r;
    e_nxt      = e_r;
    clr_nxt    = clr_r;
    report_nxt = report_r;
    used_nxt   = used_r;
    ov_nxt     = ov_r && out_stall;
    st_nxt     = st_r;
    idx_nxt    = idx_r;
    cv_nxt     = cv_r;
    cmd_pop    = 1'b0;
    slot_we    = 1'b0;
    slot_re    = 1'b0;
    ent_re     = 1'b0;
    lbl_we     = 1'b0;
    cnt_we     = 1'b0;
    slot_waddr = SA_W'(32'(tbl_r) * SLOTS + 32'(pos_r));
    slot_raddr = SA_W'(32'(tbl_r) * SLOTS + 32'(pos_r));
    slot_wd    = '0;
    go_absent  = 1'b0;
    go_found   = 1'b0;
    n_used     = used_r[tbl_r];
    ent_raddr  = EA_W'(32'(tbl_r) * MAX_ENTRIES + 32'(ENT_W'(slot_q - 1'b1)));
    lbl_waddr  = EA_W'(32'(tbl_r) * MAX_ENTRIES + 32'(n_used));
    cnt_waddr  = lbl_waddr;
    cnt_wd     = start_r;
    quot       = 32'(acc_r >> RCP_SH);
    pos_inc    = (pos_r == SLOT_W'(SLOTS - 1)) ? '0 : pos_r + 1'b1;
    sum        = {count_q[31], count_q} + {delta_r[31], delta_r};
    sat        = (sum[32] != sum[31]) ? (sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum[31:0];

    case (state_r)
      BK_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_r;
        if (clr_r == SA_W'(SA_DEPTH - 1)) begin
          state_nxt = BK_IDLE;
          if (report_r) begin
            ov_nxt  = 1'b1;
            st_nxt  = ST_CLEARED;
            idx_nxt = '0;
            cv_nxt  = '0;
          end
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      BK_IDLE: begin
        if (cmd_avail && !ov_r) begin
          cmd_pop    = 1'b1;
          op_nxt     = c_op;
          tbl_nxt    = c_tbl;
          hash_nxt   = c_hash;
          lbl_nxt    = c_lbl;
          start_nxt  = c_start;
          delta_nxt  = c_delta;
          probes_nxt = '0;
          bit_nxt    = '0;
          case (c_op)
            OP_CLEAR: begin
              for (int i = 0; i < TABLES; i++) used_nxt[i] = '0;
              clr_nxt    = '0;
              report_nxt = 1'b1;
              state_nxt  = BK_CLEAR;
            end
            OP_ADD, OP_QUERY: begin
              if (c_tv && c_fits) begin
                if (POW2) begin
                  pos_nxt   = c_hash[SLOT_W-1:0];
                  state_nxt = BK_SLOT_RD;
                end else begin
                  state_nxt = BK_MOD;
                end
              end else begin
                ov_nxt  = 1'b1;
                st_nxt  = (c_op == OP_QUERY) ? ST_ANSWERED : ST_REJECTED;
                idx_nxt = '0;
                cv_nxt  = '0;
              end
            end
            default: begin
              ov_nxt  = 1'b1;
              st_nxt  = ST_REJECTED;
              idx_nxt = '0;
              cv_nxt  = '0;
            end
          endcase
        end
      end
      BK_MOD: begin
        // hash mod SLOTS: two partial products of the reciprocal, then
        // the remainder from the quotient
        case (bit_r)
          2'd0: begin
            acc_nxt = 65'(48'(hash_r) * 48'(RCP[15:0]));
            bit_nxt = 2'd1;
          end
          2'd1: begin
            acc_nxt = acc_r + (65'(49'(hash_r) * 49'(RCP[32:16])) << 16);
            bit_nxt = 2'd2;
          end
          default: begin
            pos_nxt   = SLOT_W'(hash_r - quot * SLOTS);
            state_nxt = BK_SLOT_RD;
          end
        endcase
      end
      BK_SLOT_RD: begin
        slot_re   = 1'b1;
        state_nxt = BK_SLOT_CHK;
      end
      BK_SLOT_CHK: begin
        if (slot_q == '0) begin
          go_absent = 1'b1;
        end else begin
          ent_re    = 1'b1;
          e_nxt     = ENT_W'(slot_q - 1'b1);
          state_nxt = BK_ENT_CHK;
        end
      end
      BK_ENT_CHK: begin
        if (label_q == lbl_r) begin
          go_found = 1'b1;
        end else if (probes_r == SLOT_W'(SLOTS - 1)) begin
          go_absent = 1'b1;   // every slot taken, insert is refused below
        end else begin
          probes_nxt = probes_r + 1'b1;
          pos_nxt    = pos_inc;
          state_nxt  = BK_SLOT_RD;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase

    if (go_absent) begin
      state_nxt = BK_IDLE;
      ov_nxt    = 1'b1;
      idx_nxt   = '0;
      cv_nxt    = '0;
      if (op_r == OP_QUERY) begin
        st_nxt = ST_ANSWERED;
      end else if (32'(n_used) < ENT_LIM) begin
        slot_we          = 1'b1;
        slot_wd          = n_used + 1'b1;
        lbl_we           = 1'b1;
        cnt_we           = 1'b1;
        used_nxt[tbl_r]  = n_used + 1'b1;
        st_nxt           = ST_INSERTED;
        idx_nxt          = 8'(n_used);
        cv_nxt           = start_r;
      end else begin
        st_nxt = ST_REJECTED;
      end
    end
    if (go_found) begin
      state_nxt = BK_IDLE;
      ov_nxt    = 1'b1;
      idx_nxt   = 8'(e_r);
      if (op_r == OP_QUERY) begin
        st_nxt = ST_ANSWERED;
        cv_nxt = count_q;
      end else begin
        cnt_we    = 1'b1;
        cnt_waddr = EA_W'(32'(tbl_r) * MAX_ENTRIES + 32'(e_r));
        cnt_wd    = sat;
        st_nxt    = ST_UPDATED;
        cv_nxt    = sat;
      end
    end

    init_busy       = (state_r == BK_CLEAR) && !report_r;
    out_valid       = ov_r;
    out_status      = st_r;
    out_entry_index = idx_r;
    out_count_value = cv_r;
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wd;
    if (slot_re) slot_q <= slot_mem[slot_raddr];
    if (lbl_we) label_mem[lbl_waddr] <= lbl_r;
    if (cnt_we) count_mem[cnt_waddr] <= cnt_wd;
    if (ent_re) begin
      label_q <= label_mem[ent_raddr];
      count_q <= count_mem[ent_raddr];
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    tbl_r    <= tbl_nxt;
    hash_r   <= hash_nxt;
    lbl_r    <= lbl_nxt;
    start_r  <= start_nxt;
    delta_r  <= delta_nxt;
    pos_r    <= pos_nxt;
    acc_r    <= acc_nxt;
    probes_r <= probes_nxt;
    bit_r    <= bit_nxt;
    e_r      <= e_nxt;
    st_r     <= st_nxt;
    idx_r    <= idx_nxt;
    cv_r     <= cv_nxt;
    if (!rst_n) begin
      state_r  <= BK_CLEAR;
      clr_r    <= '0;
      report_r <= 1'b0;
      ov_r     <= 1'b0;
      for (int i = 0; i < TABLES; i++) used_r[i] <= '0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      report_r <= report_nxt;
      ov_r     <= ov_nxt;
      used_r   <= used_nxt;
    end
  end

endmodule

@@ design/keyed_counter_hash_table_core.sv @@
// Top level of the keyed counter hash table; instantiates kcht_front,
// kcht_fifo and kcht_back, all using kcht_pkg.
//
// Label-keyed saturating 32-bit counters, one table per channel and bucket.
// A label streams in one byte per transaction; the front end folds FNV-1a
// and buffers the bytes at one transaction per cycle while in_stall is low,
// and on the key_last transaction hands the whole command to a two-entry
// queue. The back end probes the selected table linearly: it takes the
// command from the queue, reduces the hash with two partial products and a
// remainder step when SLOTS is not a power of two (otherwise the low hash
// bits give the home slot), then for each slot probed does a slot read, an
// entry read and a label compare. The slot and entry memories have
// registered reads. A clear op sweeps the slot memory, one slot per cycle,
// over CHANNELS*BUCKETS*SLOTS slots (16384 by default), and its result
// shows once the sweep ends. The same sweep runs after reset; in_stall
// stays high until it finishes. Results are held in an output register
// until out_stall drops; the queue keeps taking label bytes meanwhile and
// stalls the input only when full. Stored labels and counts have no reset;
// only entries that were inserted are ever read.
module keyed_counter_hash_table_core import kcht_pkg::*; #(
  parameter int unsigned CHANNELS    = CHANNELS_DEF,
  parameter int unsigned BUCKETS     = BUCKETS_DEF,
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int unsigned LABEL_BYTES = LABEL_BYTES_DEF,
  parameter int unsigned SLOTS       = SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [1:0]  in_channel,
  input  logic [2:0]  in_bucket,
  input  logic [7:0]  in_key_char,
  input  logic        in_char_present,
  input  logic        in_key_last,
  input  logic [31:0] in_start_value,
  input  logic [31:0] in_delta,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_entry_index,
  output logic [31:0] out_count_value
);

  localparam int unsigned TABLES = CHANNELS * BUCKETS;
  localparam int unsigned TBL_W  = (TABLES > 1) ? $clog2(TABLES) : 1;
  localparam int unsigned CMD_W  = 4 + TBL_W + 32 + LABEL_BYTES * 8 + 64;

  logic             accept, push, pop, avail, full, init_busy;
  logic [CMD_W-1:0] push_data, pop_data;

  // input is held off while the queue is full or the reset sweep runs
  assign in_stall = full || init_busy;
  assign accept   = in_valid && !in_stall;

  kcht_front #(
    .CHANNELS(CHANNELS), .BUCKETS(BUCKETS), .LABEL_BYTES(LABEL_BYTES)
  ) u_front (
    .clk, .rst_n, .accept,
    .in_op, .in_channel, .in_bucket, .in_key_char, .in_char_present,
    .in_key_last, .in_start_value, .in_delta,
    .cmd_push(push), .cmd_data(push_data)
  );

  kcht_fifo #(.WIDTH(CMD_W)) u_fifo (
    .clk, .rst_n, .push, .push_data, .pop, .avail, .full, .pop_data
  );

  kcht_back #(
    .CHANNELS(CHANNELS), .BUCKETS(BUCKETS), .MAX_ENTRIES(MAX_ENTRIES),
    .LABEL_BYTES(LABEL_BYTES), .SLOTS(SLOTS)
  ) u_back (
    .clk, .rst_n,
    .cmd_avail(avail), .cmd_data(pop_data), .cmd_pop(pop), .init_busy,
    .out_valid, .out_stall, .out_status, .out_entry_index, .out_count_value
  );

endmodule

@@ design/kcht_checker.sv @@
// Port-level checks for keyed_counter_hash_table_core and the bind that
// attaches them. Depends on kcht_pkg.
module kcht_checker import kcht_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [7:0]  out_entry_index,
  input logic [31:0] out_count_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_count_value) && $stable(out_entry_index))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_CLEARED)
    else $error("unknown status code");

  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_REJECTED || out_status == ST_CLEARED)
      |-> out_entry_index == 8'd0 && out_count_value == 32'd0)
    else $error("rejected or clear result carries data");

  // a taken result leaves a gap before the next one
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid)
    else $error("result repeated after acceptance");

endmodule

bind keyed_counter_hash_table_core kcht_checker u_kcht_checker (
  .clk, .rst_n, .out_valid, .out_stall, .out_status, .out_entry_index,
  .out_count_value
);
